FILE: design/awb_pkg.sv
// ----------------------------------------------------------------------------
// awb_pkg
// Shared widths, status codes and lane types for the gain calculation core.
// ----------------------------------------------------------------------------
package awb_pkg;

    localparam int RATIO_W = 16;
    localparam int GAIN_W  = 16;
    localparam int ST_W    = 2;
    localparam int REM_W   = 16;
    localparam int ACC_W   = 25;
    localparam int DEN_W   = 16;
    localparam int LANES   = 4;
    localparam int CELLS   = ACC_W;

    localparam logic [RATIO_W-1:0] RATIO_UNITY = 16'd512;
    localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 16'h0100;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_IN   = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_CORR = 2'd2;

    localparam logic CFG_TYP_RED  = 1'b0;
    localparam logic CFG_TYP_BLUE = 1'b1;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [ACC_W-1:0] acc;
        logic [DEN_W-1:0] den;
    } awb_lane_t;

    typedef awb_lane_t [LANES-1:0] awb_lanes_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [RATIO_W-1:0] rr;
        logic [RATIO_W-1:0] br;
    } awb_side_t;

endpackage

FILE: design/awb_div_cell.sv
// ----------------------------------------------------------------------------
// awb_div_cell
// One restoring division step per lane: produces one quotient bit a cycle while adv is high.
// ----------------------------------------------------------------------------
module awb_div_cell
    import awb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  awb_lanes_t in_lanes,
    input  awb_side_t  in_side,
    output logic       out_valid,
    output awb_lanes_t out_lanes,
    output awb_side_t  out_side
);

    logic       valid_reg;
    awb_lanes_t lanes_reg, lanes_next;
    awb_side_t  side_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [REM_W:0] trial;
            logic [REM_W:0] diff;
            logic           ge;
            trial = {in_lanes[i].rem, in_lanes[i].acc[ACC_W-1]};
            diff  = trial - {1'b0, in_lanes[i].den};
            ge    = (trial >= {1'b0, in_lanes[i].den});
            lanes_next[i].rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            lanes_next[i].acc = {in_lanes[i].acc[ACC_W-2:0], ge};
            lanes_next[i].den = in_lanes[i].den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lanes_reg <= lanes_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_side  = side_reg;

endmodule

FILE: design/awb_div_chain.sv
// ----------------------------------------------------------------------------
// awb_div_chain
// Row of division cells; the full quotient leaves the last cell.
// ----------------------------------------------------------------------------
module awb_div_chain
    import awb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  awb_lanes_t in_lanes,
    input  awb_side_t  in_side,
    output logic       out_valid,
    output awb_lanes_t out_lanes,
    output awb_side_t  out_side
);

    logic       v [CELLS+1];
    awb_lanes_t l [CELLS+1];
    awb_side_t  s [CELLS+1];

    assign v[0] = in_valid;
    assign l[0] = in_lanes;
    assign s[0] = in_side;

    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        awb_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v[c]),
            .in_lanes  (l[c]),
            .in_side   (s[c]),
            .out_valid (v[c+1]),
            .out_lanes (l[c+1]),
            .out_side  (s[c+1])
        );
    end

    assign out_valid = v[CELLS];
    assign out_lanes = l[CELLS];
    assign out_side  = s[CELLS];

endmodule

FILE: design/awb_channel_gain_calc_core.sv
// ----------------------------------------------------------------------------
// awb_channel_gain_calc_core
// AWB gain calculation: correction ratios, then normalized 8.8 channel gains.
// ----------------------------------------------------------------------------
// Input transfer passes two 25-cell divider rows and then the output register
// to the result. Throughput: one item per cycle; the divider
// cells produce one quotient bit each and the whole row advances together.
// The row holds only while a result waits and m_tready is low.
// Reset: synchronous active-low aresetn clears all valid flags and both
// typical ratio registers.
module awb_channel_gain_calc_core
    import awb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_ratio[15:0], blue_ratio[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // red_gain, green_gain, blue_gain, status, zero pad
);

    logic [RATIO_W-1:0] typ_red_reg, typ_blue_reg;
    logic               adv;
    logic               out_valid_reg;
    logic [49:0]        out_data_reg, out_data_next;

    awb_lanes_t a_lanes, a_out_lanes, b_lanes, b_out_lanes;
    awb_side_t  a_side, a_out_side, b_side, b_out_side;
    logic       a_out_valid, b_out_valid;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            typ_red_reg  <= '0;
            typ_blue_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TYP_RED:  typ_red_reg  <= cfg_wdata;
                CFG_TYP_BLUE: typ_blue_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [RATIO_W-1:0] rm, bm;
    assign rm = s_tdata[15:0];
    assign bm = s_tdata[31:16];

    always_comb begin
        a_lanes        = '0;
        a_lanes[0].acc = {typ_red_reg, 9'd0};
        a_lanes[0].den = rm;
        a_lanes[1].acc = {typ_blue_reg, 9'd0};
        a_lanes[1].den = bm;
        a_side         = '0;
        a_side.status  = (rm == '0 || bm == '0 || typ_red_reg == '0 || typ_blue_reg == '0)
                         ? ST_ZERO_IN : ST_OK;
    end

    awb_div_chain u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_lanes  (a_lanes),
        .in_side   (a_side),
        .out_valid (a_out_valid),
        .out_lanes (a_out_lanes),
        .out_side  (a_out_side)
    );

    logic [RATIO_W-1:0] rr, br;
    assign rr = a_out_lanes[0].acc[RATIO_W-1:0];
    assign br = a_out_lanes[1].acc[RATIO_W-1:0];

    always_comb begin
        b_lanes        = '0;
        b_lanes[0].acc = ACC_W'(32'd131072);
        b_lanes[0].den = rr;
        b_lanes[1].acc = ACC_W'(32'd131072);
        b_lanes[1].den = br;
        b_lanes[2].acc = {1'b0, br, 8'd0};
        b_lanes[2].den = rr;
        b_lanes[3].acc = {1'b0, rr, 8'd0};
        b_lanes[3].den = br;
        b_side.rr      = rr;
        b_side.br      = br;
        if (a_out_side.status != ST_OK) begin
            b_side.status = a_out_side.status;
        end else if (rr == '0 || br == '0) begin
            b_side.status = ST_ZERO_CORR;
        end else begin
            b_side.status = ST_OK;
        end
    end

    awb_div_chain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (a_out_valid),
        .in_lanes  (b_lanes),
        .in_side   (b_side),
        .out_valid (b_out_valid),
        .out_lanes (b_out_lanes),
        .out_side  (b_out_side)
    );

    always_comb begin
        logic [GAIN_W-1:0] g_r, g_b, b_over_r, r_over_b, rg, gg, bg;
        logic              r_hi, b_hi, red_side;
        g_r      = b_out_lanes[0].acc[GAIN_W-1:0];
        g_b      = b_out_lanes[1].acc[GAIN_W-1:0];
        b_over_r = b_out_lanes[2].acc[GAIN_W-1:0];
        r_over_b = b_out_lanes[3].acc[GAIN_W-1:0];
        r_hi     = (b_out_side.rr >= RATIO_UNITY);
        b_hi     = (b_out_side.br >= RATIO_UNITY);
        if (r_hi) begin
            red_side = 1'b0;
        end else if (b_hi) begin
            red_side = 1'b1;
        end else begin
            red_side = (g_r >= g_b);
        end
        if (b_out_side.status != ST_OK) begin
            rg = '0;
            gg = '0;
            bg = '0;
        end else if (r_hi && b_hi) begin
            rg = {1'b0, b_out_side.rr[RATIO_W-1:1]};
            gg = GAIN_UNITY;
            bg = {1'b0, b_out_side.br[RATIO_W-1:1]};
        end else if (red_side) begin
            rg = GAIN_UNITY;
            gg = g_r;
            bg = b_over_r;
        end else begin
            rg = r_over_b;
            gg = g_b;
            bg = GAIN_UNITY;
        end
        out_data_next = {b_out_side.status, bg, gg, rg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= b_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule
